[hw/rtl/ifh_pkg.sv]
// Shared types and constants of the IPv4 fragment header generator.
`default_nettype none
package ifh_pkg;

   // field widths
   localparam int PROTO_W   = 8;
   localparam int HLEN_W    = 6;
   localparam int WORD_W    = 16;
   localparam int MTU_W     = 11;
   localparam int STATUS_W  = 2;
   localparam int OFFSET_W  = 13;

   // fragment word bits
   localparam int DF_POS = 14;
   localparam int MF_POS = 13;

   // protocol and fragment size limits
   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [MTU_W-1:0]   MTU_RESET = 11'd512;
   localparam logic [MTU_W-1:0]   MTU_MIN   = 11'd8;
   localparam logic [MTU_W-1:0]   MTU_CAP   = 11'd1480;
   localparam logic [MTU_W-1:0]   MTU_MASK  = 11'h7F8;
   localparam int MAX_FRAGMENTS = 64;

   // width of the payload limit mtu * MAX_FRAGMENTS, and of its compare
   localparam int LIMIT_W = MTU_W + $clog2(MAX_FRAGMENTS + 1);
   localparam int CMP_W   = (LIMIT_W > WORD_W) ? LIMIT_W : WORD_W;

   // register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MTU = 2'd0;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_PASS     = 2'd0,
      STATUS_FRAG     = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   // how the current request is handled
   typedef enum logic [1:0] {
      MODE_PASS     = 2'd0,
      MODE_FRAG     = 2'd1,
      MODE_TOO_MANY = 2'd2
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic decide;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic piece_last;
   } sts_type;

endpackage
`default_nettype wire

[hw/rtl/ifh_req_if.sv]
// Request channel: one IPv4 header descriptor.
`default_nettype none
interface ifh_req_if;
   import ifh_pkg::*;

   logic                valid;
   logic                ready;
   logic [PROTO_W-1:0]  protocol;
   logic [HLEN_W-1:0]   header_length;
   logic [WORD_W-1:0]   total_length;
   logic [WORD_W-1:0]   frag_word_in;
   logic [WORD_W-1:0]   other_words_sum;

   modport source (
      output valid, protocol, header_length, total_length, frag_word_in, other_words_sum,
      input  ready
   );
   modport sink (
      input  valid, protocol, header_length, total_length, frag_word_in, other_words_sum,
      output ready
   );
endinterface
`default_nettype wire

[hw/rtl/ifh_rsp_if.sv]
// Result channel: one fragment header per item.
`default_nettype none
interface ifh_rsp_if;
   import ifh_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   frag_word_out;
   logic [WORD_W-1:0]   frag_total_length;
   logic [WORD_W-1:0]   header_checksum;
   logic [WORD_W-1:0]   payload_start;
   logic [MTU_W-1:0]    payload_bytes;
   logic                last;

   modport source (
      output valid, status, frag_word_out, frag_total_length, header_checksum,
             payload_start, payload_bytes, last,
      input  ready
   );
   modport sink (
      input  valid, status, frag_word_out, frag_total_length, header_checksum,
             payload_start, payload_bytes, last,
      output ready
   );
endinterface
`default_nettype wire

[hw/rtl/ifh_csr.sv]
// MTU register with its APB-style access port and effective MTU clamp.
`default_nettype none
module ifh_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ifh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ifh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ifh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic      [ifh_pkg::MTU_W-1:0]      mtu_eff
);
   import ifh_pkg::*;

   logic [MTU_W-1:0] mtu_ff;
   logic [MTU_W-1:0] mtu_in;
   logic [MTU_W-1:0] mtu_masked;
   logic             wr_en;

   // write in the access phase
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr == CSR_ADDR_MTU);

   always_comb begin
      mtu_in = mtu_ff;
      if (wr_en) begin
         mtu_in = csr_pwdata[MTU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff <= MTU_RESET;
      end else begin
         mtu_ff <= mtu_in;
      end
   end

   // read back the raw register
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_MTU) begin
         csr_prdata = CSR_DATA_W'(mtu_ff);
      end
   end

   // drop the low three bits and clamp to the legal range
   assign mtu_masked = mtu_ff & MTU_MASK;
   always_comb begin
      mtu_eff = mtu_masked;
      if (mtu_masked < MTU_MIN) begin
         mtu_eff = MTU_MIN;
      end else if (mtu_masked > MTU_CAP) begin
         mtu_eff = MTU_CAP;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/ifh_ctrl.sv]
// Controller: request handshake, decide step and fragment emit sequencing.
`default_nettype none
module ifh_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ifh_pkg::cmd_type      cmd,
   input  wire ifh_pkg::sts_type sts
);
   import ifh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECIDE = 2'd1,
      ST_EMIT   = 2'd2
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd.load   = req_valid && req_ready;
      cmd.decide = (state_ff == ST_DECIDE);
      cmd.emit   = (state_ff == ST_EMIT) && out_free;
   end

   // next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.emit && sts.piece_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_to_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DECIDE)
      else $error("accepted request did not enter decide");

   a_decide_to_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |=> state_ff == ST_EMIT && !req_ready)
      else $error("decide step not followed by emit");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.piece_last |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("final result did not return to idle");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free |=> rsp_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule
`default_nettype wire

[hw/rtl/ifh_dp.sv]
// Datapath: descriptor registers, fragment walk and result register.
`default_nettype none
module ifh_dp (
   input  wire logic                         clock,
   input  wire ifh_pkg::cmd_type             cmd,
   output ifh_pkg::sts_type                  sts,
   input  wire logic [ifh_pkg::MTU_W-1:0]    mtu_eff,
   input  wire logic [ifh_pkg::PROTO_W-1:0]  protocol,
   input  wire logic [ifh_pkg::HLEN_W-1:0]   header_length,
   input  wire logic [ifh_pkg::WORD_W-1:0]   total_length,
   input  wire logic [ifh_pkg::WORD_W-1:0]   frag_word_in,
   input  wire logic [ifh_pkg::WORD_W-1:0]   other_words_sum,
   output logic      [ifh_pkg::STATUS_W-1:0] status,
   output logic      [ifh_pkg::WORD_W-1:0]   frag_word_out,
   output logic      [ifh_pkg::WORD_W-1:0]   frag_total_length,
   output logic      [ifh_pkg::WORD_W-1:0]   header_checksum,
   output logic      [ifh_pkg::WORD_W-1:0]   payload_start,
   output logic      [ifh_pkg::MTU_W-1:0]    payload_bytes,
   output logic                              last
);
   import ifh_pkg::*;

   // ones-complement header checksum over three words
   function automatic logic [WORD_W-1:0] csum3(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] c);
      logic [WORD_W+1:0] s0;
      logic [WORD_W:0]   s1;
      logic [WORD_W:0]   s2;
      s0 = (WORD_W+2)'(a) + (WORD_W+2)'(b) + (WORD_W+2)'(c);
      s1 = (WORD_W+1)'(s0[WORD_W-1:0]) + (WORD_W+1)'(s0[WORD_W+1:WORD_W]);
      s2 = (WORD_W+1)'(s1[WORD_W-1:0]) + (WORD_W+1)'(s1[WORD_W]);
      return ~s2[WORD_W-1:0];
   endfunction

   // descriptor held for the whole request
   logic [PROTO_W-1:0] protocol_ff;
   logic [HLEN_W-1:0]  hlen_ff;
   logic [WORD_W-1:0]  tlen_ff;
   logic [WORD_W-1:0]  fword_ff;
   logic [WORD_W-1:0]  others_ff;

   // decide results and walk state
   mode_type           mode_ff;
   mode_type           mode_in;
   logic [WORD_W-1:0]  payload_ff;
   logic [WORD_W-1:0]  payload_in;
   logic [WORD_W-1:0]  sent_ff;
   logic [WORD_W-1:0]  sent_in;

   // result register
   logic [STATUS_W-1:0] status_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [WORD_W-1:0]   len_ff;
   logic [WORD_W-1:0]   csum_ff;
   logic [WORD_W-1:0]   start_ff;
   logic [MTU_W-1:0]    bytes_ff;
   logic                last_ff;

   logic [LIMIT_W-1:0]  limit;
   logic                pass;

   logic                is_frag;
   logic [WORD_W-1:0]   remain;
   logic                piece_long;
   logic [MTU_W-1:0]    piece;
   logic                frag_last;
   logic [OFFSET_W-1:0] offset;
   logic [WORD_W-1:0]   word;
   logic [WORD_W-1:0]   len;
   logic [STATUS_W-1:0] status_in;
   logic [WORD_W-1:0]   start_in;
   logic [MTU_W-1:0]    bytes_in;

   // classify the request: pass, fragment, or too many pieces
   always_comb begin
      payload_in = (tlen_ff > WORD_W'(hlen_ff)) ? (tlen_ff - WORD_W'(hlen_ff)) : '0;
      limit = LIMIT_W'(mtu_eff) * LIMIT_W'(MAX_FRAGMENTS);
      pass  = (protocol_ff != PROTO_TCP) || (tlen_ff <= WORD_W'(mtu_eff))
              || (payload_in == '0);
      if (pass) begin
         mode_in = MODE_PASS;
      end else if (CMP_W'(payload_in) > CMP_W'(limit)) begin
         mode_in = MODE_TOO_MANY;
      end else begin
         mode_in = MODE_FRAG;
      end
   end

   // current piece of the walk
   always_comb begin
      is_frag    = (mode_ff == MODE_FRAG);
      remain     = payload_ff - sent_ff;
      piece_long = remain > WORD_W'(mtu_eff);
      piece      = piece_long ? mtu_eff : remain[MTU_W-1:0];
      frag_last  = !piece_long;
      offset     = fword_ff[OFFSET_W-1:0] + sent_ff[WORD_W-1:3];
      sts.piece_last = !is_frag || frag_last;
      sent_in    = sent_ff + WORD_W'(piece);

      if (is_frag) begin
         word = WORD_W'(offset);
         word[DF_POS] = 1'b1;
         word[MF_POS] = !frag_last || fword_ff[MF_POS];
         len       = WORD_W'(hlen_ff) + WORD_W'(piece);
         status_in = STATUS_FRAG;
         start_in  = sent_ff;
         bytes_in  = piece;
      end else begin
         word      = fword_ff;
         len       = tlen_ff;
         status_in = (mode_ff == MODE_TOO_MANY) ? STATUS_TOO_MANY : STATUS_PASS;
         start_in  = '0;
         bytes_in  = '0;
      end
   end

   // hold descriptor, walk state and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         protocol_ff <= protocol;
         hlen_ff     <= header_length;
         tlen_ff     <= total_length;
         fword_ff    <= frag_word_in;
         others_ff   <= other_words_sum;
      end
      if (cmd.decide) begin
         mode_ff    <= mode_in;
         payload_ff <= payload_in;
         sent_ff    <= '0;
      end else if (cmd.emit) begin
         sent_ff    <= sent_in;
      end
      if (cmd.emit) begin
         status_ff <= status_in;
         word_ff   <= word;
         len_ff    <= len;
         csum_ff   <= csum3(others_ff, len, word);
         start_ff  <= start_in;
         bytes_ff  <= bytes_in;
         last_ff   <= sts.piece_last;
      end
   end

   assign status            = status_ff;
   assign frag_word_out     = word_ff;
   assign frag_total_length = len_ff;
   assign header_checksum   = csum_ff;
   assign payload_start     = start_ff;
   assign payload_bytes     = bytes_ff;
   assign last              = last_ff;

endmodule
`default_nettype wire

[hw/rtl/ipv4_fragment_header_generator_unit.sv]
// Top level of the IPv4 fragment header generator.
//
//   port group   direction  width/kind           purpose
//   req          in         ifh_req_if.sink      IPv4 header descriptor request
//   rsp          out        ifh_rsp_if.source    fragment header results
//   csr_*        in/out     APB-style, 32 bit    mtu register (byte address 0)
//
// A request is accepted in the idle state and classified in the decide state; the emit
// state then gives one result per cycle while the output register can take it. The emit
// sequencer sets this; the next request is taken once the final result is in the output register.
// Reset clears the controller and sets mtu to 512. A stalled result holds the
// output register and pauses the fragment walk.
`default_nettype none
module ipv4_fragment_header_generator_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ifh_req_if.sink                             req,
   ifh_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ifh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ifh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ifh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ifh_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [MTU_W-1:0] mtu_eff;

   // mtu register
   ifh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mtu_eff     (mtu_eff)
   );

   // sequencer
   ifh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // fragment datapath
   ifh_dp u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .sts               (sts),
      .mtu_eff           (mtu_eff),
      .protocol          (req.protocol),
      .header_length     (req.header_length),
      .total_length      (req.total_length),
      .frag_word_in      (req.frag_word_in),
      .other_words_sum   (req.other_words_sum),
      .status            (rsp.status),
      .frag_word_out     (rsp.frag_word_out),
      .frag_total_length (rsp.frag_total_length),
      .header_checksum   (rsp.header_checksum),
      .payload_start     (rsp.payload_start),
      .payload_bytes     (rsp.payload_bytes),
      .last              (rsp.last)
   );

endmodule
`default_nettype wire

[tb/sv/ifh_fragment_checker.sv]
`timescale 1ns / 100ps
// Fragment header checker: predicts the results of each request and compares them.
module ifh_fragment_checker (
   input  logic                           clock,
   input  logic                           reset,
   ifh_req_if                             req,
   ifh_rsp_if                             rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ifh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ifh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             pending,
   output int                             fail_count
);
   import ifh_pkg::*;

   typedef struct {
      status_type        status;
      logic [WORD_W-1:0] frag_word;
      logic [WORD_W-1:0] total_len;
      logic [WORD_W-1:0] csum;
      logic [WORD_W-1:0] start;
      logic [MTU_W-1:0]  nbytes;
      logic              last;
   } frag_hdr_type;

   frag_hdr_type     expected_hdrs[$];
   logic [MTU_W-1:0] mtu_reg;
   int               fails = 0;

   // ones-complement header checksum over the supplied sum, length and fragment word
   function automatic logic [WORD_W-1:0] header_csum(input logic [WORD_W-1:0] others,
                                                     input logic [WORD_W-1:0] len,
                                                     input logic [WORD_W-1:0] word);
      logic [WORD_W+1:0] s;
      s = {2'b00, others} + len + word;
      s = s[WORD_W-1:0] + s[WORD_W+1:WORD_W];
      s = s[WORD_W-1:0] + s[WORD_W+1:WORD_W];
      return ~s[WORD_W-1:0];
   endfunction

   function automatic void add_header(input status_type st,
                                      input logic [WORD_W-1:0] word,
                                      input logic [WORD_W-1:0] len,
                                      input logic [WORD_W-1:0] start,
                                      input logic [MTU_W-1:0] nbytes,
                                      input logic fin,
                                      input logic [WORD_W-1:0] others);
      frag_hdr_type h;
      h.status    = st;
      h.frag_word = word;
      h.total_len = len;
      h.csum      = header_csum(others, len, word);
      h.start     = start;
      h.nbytes    = nbytes;
      h.last      = fin;
      expected_hdrs.push_back(h);
   endfunction

   // split one request into its fragment headers, or a single pass header
   function automatic void predict_fragments(input logic [PROTO_W-1:0] proto,
                                             input logic [HLEN_W-1:0] hlen,
                                             input logic [WORD_W-1:0] tlen,
                                             input logic [WORD_W-1:0] fword,
                                             input logic [WORD_W-1:0] others);
      int                  m;
      int                  payload;
      int                  count;
      int                  sent;
      int                  piece;
      int                  k;
      logic                fin;
      logic [WORD_W-1:0]   word;
      m = int'(mtu_reg & MTU_MASK);
      if (m < int'(MTU_MIN)) m = int'(MTU_MIN);
      if (m > int'(MTU_CAP)) m = int'(MTU_CAP);
      payload = (tlen > hlen) ? int'(tlen) - int'(hlen) : 0;
      count = (payload + m - 1) / m;
      if (proto != PROTO_TCP || int'(tlen) <= m || payload == 0) begin
         add_header(STATUS_PASS, fword, tlen, '0, '0, 1'b1, others);
      end else if (count > MAX_FRAGMENTS) begin
         add_header(STATUS_TOO_MANY, fword, tlen, '0, '0, 1'b1, others);
      end else begin
         sent = 0;
         for (k = 0; k < count; k++) begin
            piece = (payload - sent > m) ? m : payload - sent;
            fin   = (payload - sent - piece == 0);
            // drop reserved and DF of the input, wrap the offset, force DF
            word = '0;
            word[OFFSET_W-1:0] = fword[OFFSET_W-1:0] + OFFSET_W'(sent >> 3);
            word[DF_POS] = 1'b1;
            word[MF_POS] = !fin || fword[MF_POS];
            add_header(STATUS_FRAG, word, WORD_W'(int'(hlen) + piece), WORD_W'(sent),
                       MTU_W'(piece), fin, others);
            sent += piece;
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      frag_hdr_type want;
      if (reset) begin
         mtu_reg = MTU_RESET;
         expected_hdrs.delete();
      end else begin
         // compare an accepted result with the oldest expected header
         if (rsp.valid && rsp.ready) begin
            if (expected_hdrs.size() == 0) begin
               $display("%0t: unexpected result expected none actual status %h word %h len %h",
                        $time, rsp.status, rsp.frag_word_out, rsp.frag_total_length);
               fails++;
            end else begin
               want = expected_hdrs.pop_front();
               check_field("status", want.status, rsp.status);
               check_field("frag_word_out", want.frag_word, rsp.frag_word_out);
               check_field("frag_total_length", want.total_len, rsp.frag_total_length);
               check_field("header_checksum", want.csum, rsp.header_checksum);
               check_field("payload_start", want.start, rsp.payload_start);
               check_field("payload_bytes", want.nbytes, rsp.payload_bytes);
               check_field("last", want.last, rsp.last);
            end
         end
         // predict the headers of an accepted request
         if (req.valid && req.ready)
            predict_fragments(req.protocol, req.header_length, req.total_length,
                              req.frag_word_in, req.other_words_sum);
         // track the mtu register
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_ADDR_MTU)
            mtu_reg = csr_pwdata[MTU_W-1:0];
      end
      pending    <= expected_hdrs.size();
      fail_count <= fails;
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, mtu writes, request stimulus and the verdict.
module tb;
   import ifh_pkg::*;

   localparam int ITEMS_PER_PHASE = 23;
   localparam int NUM_PHASES      = 7;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 4;
   localparam int END_CYCLES      = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  no_idle;
   logic                  hold_req;
   int                    pending;
   int                    fail_count;
   int                    eff_mtu = int'(MTU_RESET);

   ifh_req_if req_ch();
   ifh_rsp_if rsp_ch();

   ipv4_fragment_header_generator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ifh_fragment_checker frag_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   always #10 clock = ~clock;

   // give up after a generous fixed time
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 34);
         end
      end
   end

   // offer one request, with random idle cycles ahead of it; leave valid high
   task automatic send_request(input logic [PROTO_W-1:0] pr, input logic [HLEN_W-1:0] hl,
                               input logic [WORD_W-1:0] tl, input logic [WORD_W-1:0] fw,
                               input logic [WORD_W-1:0] os);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.protocol        <= pr;
      req_ch.header_length   <= hl;
      req_ch.total_length    <= tl;
      req_ch.frag_word_in    <= fw;
      req_ch.other_words_sum <= os;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop valid and hold until every expected result has come
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mtu(input logic [MTU_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_MTU;
      csr_pwdata  <= {(CSR_DATA_W-MTU_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // keep the effective size for sizing the stimulus
      eff_mtu = int'(value & MTU_MASK);
      if (eff_mtu < int'(MTU_MIN)) eff_mtu = int'(MTU_MIN);
      if (eff_mtu > int'(MTU_CAP)) eff_mtu = int'(MTU_CAP);
   endtask

   task automatic send_random();
      int                 pick;
      int                 k;
      int                 hl;
      int                 pay;
      logic [PROTO_W-1:0] pr;
      logic [WORD_W-1:0]  tl;
      pick = $urandom_range(99);
      hl = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(60, 20);
      pr = PROTO_TCP;
      if (pick < 62) begin
         // well-formed split: mostly a few pieces, now and then up to the limit
         k = ($urandom_range(7) == 0) ? $urandom_range(MAX_FRAGMENTS, 1) : $urandom_range(6, 1);
         pay = (k - 1) * eff_mtu + $urandom_range(eff_mtu, 1);
         if (hl + pay > 65535) pay = 65535 - hl;
         tl = WORD_W'(hl + pay);
      end else if (pick < 72 && MAX_FRAGMENTS * eff_mtu + hl < 65535) begin
         // too many pieces
         tl = WORD_W'($urandom_range(65535, MAX_FRAGMENTS * eff_mtu + hl + 1));
      end else if (pick < 86) begin
         // other protocols pass
         pr = PROTO_W'($urandom);
         if (pr == PROTO_TCP) pr = ~PROTO_TCP;
         tl = WORD_W'($urandom);
      end else begin
         if ($urandom_range(1)) pr = PROTO_W'($urandom);
         tl = WORD_W'($urandom);
      end
      send_request(pr, HLEN_W'(hl), tl, WORD_W'($urandom), WORD_W'($urandom));
   endtask

   initial begin
      logic [MTU_W-1:0] phase_mtu [NUM_PHASES];
      req_ch.valid           <= 1'b0;
      req_ch.protocol        <= '0;
      req_ch.header_length   <= '0;
      req_ch.total_length    <= '0;
      req_ch.frag_word_in    <= '0;
      req_ch.other_words_sum <= '0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      no_idle                <= 1'b0;
      hold_req               <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset mtu
      send_request(8'd17, 6'd20, 16'd1500, 16'h4000, 16'h1234);   // not TCP
      send_request(PROTO_TCP, 6'd20, 16'd512, 16'h0000, 16'h0000); // length equal to mtu
      send_request(PROTO_TCP, 6'd20, 16'd513, 16'h0000, 16'hABCD); // single piece
      send_request(PROTO_TCP, 6'd20, 16'd1500, 16'h0000, 16'h0000);
      send_request(PROTO_TCP, 6'd60, 16'd1500, 16'hFFFF, 16'hFFFF); // offset wrap, MF in
      send_request(PROTO_TCP, 6'd20, 16'd32788, 16'h2000, 16'h0001); // exactly the limit
      send_request(PROTO_TCP, 6'd20, 16'd32789, 16'h0000, 16'h0002); // one piece too many
      send_request(PROTO_TCP, 6'd63, 16'hFFFF, 16'hBFFF, 16'hFFFF);
      send_request(8'd0, 6'd0, 16'd0, 16'h0000, 16'h0000);
      send_request(8'hFF, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(8'd7, 6'd20, 16'd2000, 16'h1FFF, 16'h8000);
      send_request(PROTO_TCP, 6'd0, 16'd1024, 16'h1000, 16'h7FFF); // whole pieces only

      // smallest mtu: header longer than the packet
      set_mtu(11'd8);
      send_request(PROTO_TCP, 6'd60, 16'd40, 16'h0000, 16'h0000);
      send_request(PROTO_TCP, 6'd20, 16'd20, 16'h0000, 16'h0000);
      send_request(PROTO_TCP, 6'd20, 16'd532, 16'h1FF8, 16'h4321);
      send_request(PROTO_TCP, 6'd20, 16'd533, 16'h0000, 16'h0000);
      set_mtu(11'd0);
      send_request(PROTO_TCP, 6'd20, 16'd100, 16'h0000, 16'hFFFE);
      set_mtu(11'd7);
      send_request(PROTO_TCP, 6'd20, 16'd29, 16'h2000, 16'h0000);

      // largest values: saturate to the cap, low bits ignored
      set_mtu(11'h7FF);
      send_request(PROTO_TCP, 6'd20, 16'd9020, 16'h0000, 16'h5555);
      send_request(PROTO_TCP, 6'd20, 16'hFFFF, 16'h0100, 16'hAAAA);
      set_mtu(11'd1487);
      send_request(PROTO_TCP, 6'd20, 16'd1500, 16'h0000, 16'h0000);
      send_request(PROTO_TCP, 6'd20, 16'd1501, 16'h2000, 16'h0000);

      // random phases over several mtu settings
      phase_mtu = '{11'd512, 11'd1000, 11'd8, 11'd1480, 11'($urandom), 11'($urandom), 11'd200};
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_mtu(phase_mtu[p]);
         no_idle <= (p == 1);
         if (p == 3) hold_req <= 1'b1;
         repeat (ITEMS_PER_PHASE) send_random();
      end

      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
